// ===== rtl/core/mtq_pkg.sv =====
// mtq_pkg: shared sizes, codes and control structs of the max tracking queue
// depends on: nothing

package mtq_pkg;

  // queue sizing
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 11;
  localparam int unsigned STS_W = 2;

  localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;

  // request command codes
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } sts_e;

  // controller states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_EXEC  = 7'b000_0010,
    S_XFER  = 7'b000_0100,
    S_POPRD = 7'b000_1000,
    S_POP   = 7'b001_0000,
    S_MAXRD = 7'b010_0000,
    S_FIN   = 7'b100_0000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec_enq;
    logic deq_empty;
    logic xfer_step;
    logic pop_read;
    logic pop;
    logic max_load;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_deq;
    logic held_zero;
    logic out_empty;
    logic in_empty;
    logic pop_reload;
  } dp_sts_t;

endpackage

// ===== rtl/core/mtq_if.sv =====
// mtq_req_if / mtq_rsp_if: request and result channels with valid/ready
// depends on: mtq_pkg

interface mtq_req_if import mtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface mtq_rsp_if import mtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic signed [31:0] current_max;
  logic [STS_W-1:0]   status;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, data, current_max, status, occupancy, input ready);
  modport sink   (input valid, data, current_max, status, occupancy, output ready);
endinterface

// ===== rtl/core/max_tracking_queue_unit.sv =====
// max_tracking_queue_unit: first-in first-out queue with running maximum
// depends on: mtq_pkg, mtq_if, mtq_ctrl, mtq_datapath
//
// Usage
//   req_i carries one beat per command: command 0 enqueues value, 1 dequeues
//   the oldest entry. rsp_o returns exactly one beat per request with the
//   dequeued value, the maximum still held, a status code and the occupancy.
//   The queue is two stacks in memory with a stack of running maxima on the
//   output side; the input side keeps only its top maximum in a register.
// Operation
//   One request is in flight at a time. An enqueue or a dequeue from an empty
//   queue completes in EXEC and FIN; a dequeue from a non-empty output stack
//   adds the registered memory reads of the pop, and MAXRD when a maximum
//   below a popped one must be refetched. A dequeue that finds the output
//   stack empty first moves all n entries of the input stack across, one per
//   cycle through the memory read port. A new request is taken once the
//   previous one has reached the result register.
// Reset and stalls
//   Reset empties the queue at once; memory contents need no clearing. While
//   rsp_o is stalled the result register holds its beat, and the next
//   request is accepted and worked on up to the point of delivery.

module max_tracking_queue_unit import mtq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtq_req_if.sink   req_i,
  mtq_rsp_if.source rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer
  mtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // stacks and result register
  mtq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .command_i     (req_i.command),
    .value_i       (req_i.value),
    .data_o        (rsp_o.data),
    .current_max_o (rsp_o.current_max),
    .status_o      (rsp_o.status),
    .occupancy_o   (rsp_o.occupancy)
  );

endmodule

// ===== rtl/core/mtq_datapath.sv =====
// mtq_datapath: stack memories, counts, cached maxima and the result register
// depends on: mtq_pkg

module mtq_datapath import mtq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                command_i,
  input  logic signed [31:0]  value_i,
  output logic signed [31:0]  data_o,
  output logic signed [31:0]  current_max_o,
  output logic [STS_W-1:0]    status_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  // input stack keeps only its top maximum: it is only ever drained whole
  logic signed [31:0] in_vals_mem  [DEPTH];
  logic signed [31:0] out_vals_mem [DEPTH];
  logic signed [31:0] out_max_mem  [DEPTH];

  logic [CW-1:0]      ivc_q, ivc_d;
  logic [CW-1:0]      ovc_q, ovc_d;
  logic [CW-1:0]      omc_q, omc_d;
  logic               pend_q, pend_d;
  logic signed [31:0] in_top_q, in_top_d;
  logic signed [31:0] out_top_q, out_top_d;
  logic signed [31:0] data_q, data_d;
  sts_e               sts_q, sts_d;
  logic               cmd_q;
  logic signed [31:0] value_q;
  logic signed [31:0] in_rd_q, ov_rd_q, om_rd_q;

  logic [CW-1:0]      held;
  logic               full;
  logic               iv_we, ov_we, om_we;
  logic [AW-1:0]      iv_waddr, ov_waddr, om_waddr;
  logic signed [31:0] iv_wdata, ov_wdata, om_wdata;
  logic               iv_re, ov_re, om_re;
  logic [AW-1:0]      iv_raddr, ov_raddr, om_raddr;
  logic [CW-1:0]      ovc_m1, omc_m1, omc_m2, ivc_m1;
  logic signed [31:0] lmax, rmax;

  assign held   = ivc_q + ovc_q;
  assign full   = (held >= CW'(DEPTH));
  assign ivc_m1 = ivc_q - CW'(1);
  assign ovc_m1 = ovc_q - CW'(1);
  assign omc_m1 = omc_q - CW'(1);
  assign omc_m2 = omc_q - CW'(2);

  // status toward the controller
  assign sts_o.cmd_deq    = (cmd_q == CMD_DEQ);
  assign sts_o.held_zero  = (held == '0);
  assign sts_o.out_empty  = (ovc_q == '0);
  assign sts_o.in_empty   = (ivc_q == '0);
  assign sts_o.pop_reload = (ov_rd_q == out_top_q) && (omc_q > CW'(1));

  // per-command state update and memory port control
  always_comb begin
    ivc_d     = ivc_q;
    ovc_d     = ovc_q;
    omc_d     = omc_q;
    pend_d    = pend_q;
    in_top_d  = in_top_q;
    out_top_d = out_top_q;
    data_d    = data_q;
    sts_d     = sts_q;
    iv_we     = 1'b0;
    iv_waddr  = ivc_q[AW-1:0];
    iv_wdata  = value_q;
    ov_we     = 1'b0;
    ov_waddr  = ovc_q[AW-1:0];
    ov_wdata  = in_rd_q;
    om_we     = 1'b0;
    om_waddr  = omc_q[AW-1:0];
    om_wdata  = in_rd_q;
    iv_re     = 1'b0;
    iv_raddr  = ivc_m1[AW-1:0];
    ov_re     = 1'b0;
    ov_raddr  = ovc_m1[AW-1:0];
    om_re     = 1'b0;
    om_raddr  = omc_m2[AW-1:0];

    if (cmd_i.exec_enq) begin
      data_d = MIN_WORD;
      if (full) begin
        sts_d = STS_FULL;
      end else begin
        sts_d = STS_OK;
        iv_we = 1'b1;
        ivc_d = ivc_q + CW'(1);
        if ((ivc_q == '0) || (value_q >= in_top_q)) begin
          in_top_d = value_q;
        end
      end
    end

    if (cmd_i.deq_empty) begin
      data_d = MIN_WORD;
      sts_d  = STS_EMPTY;
    end

    // transfer: read input stack top down, push the previous beat onto output
    if (cmd_i.xfer_step) begin
      if (ivc_q != '0) begin
        iv_re  = 1'b1;
        ivc_d  = ivc_m1;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q) begin
        ov_we = 1'b1;
        ovc_d = ovc_q + CW'(1);
        if ((omc_q == '0) || (in_rd_q >= out_top_q)) begin
          om_we     = 1'b1;
          omc_d     = omc_q + CW'(1);
          out_top_d = in_rd_q;
        end
      end
    end

    if (cmd_i.pop_read) begin
      ov_re = 1'b1;
    end

    // pop the output stack, refetch the maximum below a popped one
    if (cmd_i.pop) begin
      data_d = ov_rd_q;
      sts_d  = STS_OK;
      ovc_d  = ovc_m1;
      if (ov_rd_q == out_top_q) begin
        omc_d = omc_m1;
        if (omc_q > CW'(1)) begin
          om_re = 1'b1;
        end
      end
    end

    if (cmd_i.max_load) begin
      out_top_d = om_rd_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivc_q  <= '0;
      ovc_q  <= '0;
      omc_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      ivc_q  <= ivc_d;
      ovc_q  <= ovc_d;
      omc_q  <= omc_d;
      pend_q <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_top_q  <= in_top_d;
    out_top_q <= out_top_d;
    data_q    <= data_d;
    sts_q     <= sts_d;
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      value_q <= value_i;
    end
  end

  // stack memories
  always_ff @(posedge clk_i) begin
    if (iv_we) begin
      in_vals_mem[iv_waddr] <= iv_wdata;
    end
    if (iv_re) begin
      in_rd_q <= in_vals_mem[iv_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_we) begin
      out_vals_mem[ov_waddr] <= ov_wdata;
    end
    if (ov_re) begin
      ov_rd_q <= out_vals_mem[ov_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (om_we) begin
      out_max_mem[om_waddr] <= om_wdata;
    end
    if (om_re) begin
      om_rd_q <= out_max_mem[om_raddr];
    end
  end

  // result register
  assign lmax = (omc_q != '0) ? out_top_q : MIN_WORD;
  assign rmax = (ivc_q != '0) ? in_top_q : MIN_WORD;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      data_o        <= data_q;
      current_max_o <= (lmax >= rmax) ? lmax : rmax;
      status_o      <= sts_q;
      occupancy_o   <= OCC_W'(held);
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) omc_q <= ovc_q)
    else $error("output maxima count above value count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) held <= CW'(DEPTH))
    else $error("queue holds more than its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_i.pop || cmd_i.pop_read) |-> (ovc_q != '0))
    else $error("pop from an empty output stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.xfer_step && pend_q |=> (ovc_q == $past(ovc_q) + CW'(1)))
    else $error("transfer beat lost");

endmodule

// ===== rtl/core/mtq_ctrl.sv =====
// mtq_ctrl: sequencer for enqueue, stack transfer and dequeue, result handshake
// depends on: mtq_pkg

module mtq_ctrl import mtq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.cmd_deq) begin
          cmd_o.exec_enq = 1'b1;
          state_d        = S_FIN;
        end else if (sts_i.held_zero) begin
          cmd_o.deq_empty = 1'b1;
          state_d         = S_FIN;
        end else if (sts_i.out_empty) begin
          state_d = S_XFER;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = S_POP;
        end
      end
      S_XFER: begin
        cmd_o.xfer_step = 1'b1;
        if (sts_i.in_empty) begin
          state_d = S_POPRD;
        end
      end
      S_POPRD: begin
        cmd_o.pop_read = 1'b1;
        state_d        = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = sts_i.pop_reload ? S_MAXRD : S_FIN;
      end
      S_MAXRD: begin
        cmd_o.max_load = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && !out_ready_i |-> !cmd_o.load_out)
    else $error("result overwritten before taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.capture |=> (state_q == S_EXEC))
    else $error("accepted beat not executed");

endmodule
